// ===== rtl/dual_incremental_pid_q10_top_defines.svh =====
// Assertion macros for the dual incremental PID block.
// Taken in by the modules that carry concurrent checks; expects aclk and aresetn in scope.
`ifndef DUAL_INCREMENTAL_PID_Q10_TOP_DEFINES_SVH
`define DUAL_INCREMENTAL_PID_Q10_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DIPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define DIPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dipq_pkg.sv =====
// Shared widths, register indexes and types for the dual incremental PID block.
// No dependencies; used by every RTL module through scoped names.
package dipq_pkg;

    localparam int SPEED_W   = 16;
    localparam int BASE_W    = 17;
    localparam int DRIVE_W   = 17;
    localparam int ADJ_W     = 18;
    localparam int GAIN_W    = 14;
    localparam int MASK_W    = 2;
    localparam int LIMIT_W   = 16;

    // error and its differences
    localparam int E_W       = SPEED_W + 1;
    localparam int D1_W      = E_W + 1;
    localparam int D2_W      = E_W + 2;

    // gain products and their sum
    localparam int PKP_W     = GAIN_W + D1_W;
    localparam int PKI_W     = GAIN_W + E_W;
    localparam int PKD_W     = GAIN_W + D2_W;
    localparam int INC_W     = PKD_W + 2;

    // drive sum before clamping
    localparam int DSUM_W    = ADJ_W + 1;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 72;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_LEFT_KP     = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LEFT_KI     = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LEFT_KD     = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_KP    = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_KI    = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_KD    = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_MASK = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_MOTOR_LIMIT = 4'd7;

    localparam logic [MASK_W-1:0]  MASK_RESET  = 2'd3;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd3600;

    localparam logic signed [ADJ_W-1:0] ADJ_LIM = 18'sd131070;

    typedef struct packed {
        logic [GAIN_W-1:0]  left_kp;
        logic [GAIN_W-1:0]  left_ki;
        logic [GAIN_W-1:0]  left_kd;
        logic [GAIN_W-1:0]  right_kp;
        logic [GAIN_W-1:0]  right_ki;
        logic [GAIN_W-1:0]  right_kd;
        logic [MASK_W-1:0]  enable_mask;
        logic [LIMIT_W-1:0] motor_limit;
    } cfg_regs_t;

    // stage load strobes: products, accumulator, adjustment
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } stage_ctrl_t;

endpackage

// ===== rtl/dipq_cfg.sv =====
// Configuration register file for the dual incremental PID block.
// Depends on dipq_pkg for register indexes, reset values and cfg_regs_t.
module dipq_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dipq_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dipq_pkg::CFG_DATA_W-1:0]     cfg_data,
    output dipq_pkg::cfg_regs_t                 regs
);

    dipq_pkg::cfg_regs_t regs_reg;

    assign cfg_ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg.left_kp     <= '0;
            regs_reg.left_ki     <= '0;
            regs_reg.left_kd     <= '0;
            regs_reg.right_kp    <= '0;
            regs_reg.right_ki    <= '0;
            regs_reg.right_kd    <= '0;
            regs_reg.enable_mask <= dipq_pkg::MASK_RESET;
            regs_reg.motor_limit <= dipq_pkg::LIMIT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                dipq_pkg::REG_LEFT_KP: begin
                    regs_reg.left_kp <= cfg_data[dipq_pkg::GAIN_W-1:0];
                end
                dipq_pkg::REG_LEFT_KI: begin
                    regs_reg.left_ki <= cfg_data[dipq_pkg::GAIN_W-1:0];
                end
                dipq_pkg::REG_LEFT_KD: begin
                    regs_reg.left_kd <= cfg_data[dipq_pkg::GAIN_W-1:0];
                end
                dipq_pkg::REG_RIGHT_KP: begin
                    regs_reg.right_kp <= cfg_data[dipq_pkg::GAIN_W-1:0];
                end
                dipq_pkg::REG_RIGHT_KI: begin
                    regs_reg.right_ki <= cfg_data[dipq_pkg::GAIN_W-1:0];
                end
                dipq_pkg::REG_RIGHT_KD: begin
                    regs_reg.right_kd <= cfg_data[dipq_pkg::GAIN_W-1:0];
                end
                dipq_pkg::REG_ENABLE_MASK: begin
                    regs_reg.enable_mask <= cfg_data[dipq_pkg::MASK_W-1:0];
                end
                dipq_pkg::REG_MOTOR_LIMIT: begin
                    regs_reg.motor_limit <= cfg_data[dipq_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/dipq_wheel.sv =====
// One wheel of the incremental PID: error history, gain products, saturating
// accumulator and clamped, shifted adjustment. Depends on dipq_pkg.
module dipq_wheel #(
    parameter int ACCUM_WIDTH = 48,
    parameter int FRAC_BITS   = 10
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  dipq_pkg::stage_ctrl_t                       ctrl,
    input  logic                                        en,
    input  logic [dipq_pkg::GAIN_W-1:0]                 kp,
    input  logic [dipq_pkg::GAIN_W-1:0]                 ki,
    input  logic [dipq_pkg::GAIN_W-1:0]                 kd,
    input  logic [dipq_pkg::LIMIT_W-1:0]                lim,
    input  logic signed [dipq_pkg::SPEED_W-1:0]         target,
    input  logic signed [dipq_pkg::SPEED_W-1:0]         meas,
    output logic signed [dipq_pkg::ADJ_W-1:0]           adjust
);

    localparam int SUM_W = ((ACCUM_WIDTH > dipq_pkg::INC_W) ?
                            ACCUM_WIDTH : dipq_pkg::INC_W) + 1;
    localparam int BND_W = dipq_pkg::LIMIT_W + FRAC_BITS + 1;
    localparam int CMP_W = ((ACCUM_WIDTH > BND_W) ? ACCUM_WIDTH : BND_W) + 1;

    localparam logic signed [SUM_W-1:0] ACC_MAX =
        $signed({{(SUM_W-ACCUM_WIDTH+1){1'b0}}, {(ACCUM_WIDTH-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] ACC_MIN =
        $signed({{(SUM_W-ACCUM_WIDTH+1){1'b1}}, {(ACCUM_WIDTH-1){1'b0}}});

    logic signed [dipq_pkg::E_W-1:0]    e1_reg, e2_reg;
    logic signed [dipq_pkg::PKP_W-1:0]  pkp_reg, pkp_next;
    logic signed [dipq_pkg::PKI_W-1:0]  pki_reg, pki_next;
    logic signed [dipq_pkg::PKD_W-1:0]  pkd_reg, pkd_next;
    logic signed [ACCUM_WIDTH-1:0]      accum_reg, accum_next;
    logic signed [dipq_pkg::ADJ_W-1:0]  adj_reg, adj_next;

    logic signed [dipq_pkg::E_W-1:0]    e_c;
    logic signed [dipq_pkg::D1_W-1:0]   d1;
    logic signed [dipq_pkg::D2_W-1:0]   d2;
    logic signed [dipq_pkg::PKP_W-1:0]  kp_x, d1_x;
    logic signed [dipq_pkg::PKI_W-1:0]  ki_x, e_x;
    logic signed [dipq_pkg::PKD_W-1:0]  kd_x, d2_x;
    logic signed [dipq_pkg::INC_W-1:0]  inc;
    logic signed [SUM_W-1:0]            acc_sum;
    logic signed [CMP_W-1:0]            bound, acc_x, u, sh;
    logic signed [dipq_pkg::ADJ_W-1:0]  sh_n;

    assign adjust = adj_reg;

    // error, differences and gain products
    always_comb begin
        e_c  = dipq_pkg::E_W'(meas) - dipq_pkg::E_W'(target);
        d1   = dipq_pkg::D1_W'(e_c) - dipq_pkg::D1_W'(e1_reg);
        d2   = dipq_pkg::D2_W'(e_c) - (dipq_pkg::D2_W'(e1_reg) <<< 1)
             + dipq_pkg::D2_W'(e2_reg);
        kp_x = $signed(dipq_pkg::PKP_W'(kp));
        d1_x = dipq_pkg::PKP_W'(d1);
        ki_x = $signed(dipq_pkg::PKI_W'(ki));
        e_x  = dipq_pkg::PKI_W'(e_c);
        kd_x = $signed(dipq_pkg::PKD_W'(kd));
        d2_x = dipq_pkg::PKD_W'(d2);
        pkp_next = kp_x * d1_x;
        pki_next = ki_x * e_x;
        pkd_next = kd_x * d2_x;
    end

    // saturating accumulate, cleared while the wheel is disabled
    always_comb begin
        inc = dipq_pkg::INC_W'(pkp_reg) + dipq_pkg::INC_W'(pki_reg)
            + dipq_pkg::INC_W'(pkd_reg);
        acc_sum = SUM_W'(accum_reg) + SUM_W'(inc);
        if (!en) begin
            accum_next = '0;
        end else if (acc_sum > ACC_MAX) begin
            accum_next = ACCUM_WIDTH'(ACC_MAX);
        end else if (acc_sum < ACC_MIN) begin
            accum_next = ACCUM_WIDTH'(ACC_MIN);
        end else begin
            accum_next = acc_sum[ACCUM_WIDTH-1:0];
        end
    end

    // clamp to twice the limit in Q format, drop fraction, negate
    always_comb begin
        bound = $signed(CMP_W'(lim)) <<< (FRAC_BITS + 1);
        acc_x = CMP_W'(accum_reg);
        if (acc_x > bound) begin
            u = bound;
        end else if (acc_x < -bound) begin
            u = -bound;
        end else begin
            u = acc_x;
        end
        sh       = u >>> FRAC_BITS;
        sh_n     = dipq_pkg::ADJ_W'(sh);
        adj_next = -sh_n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_reg    <= '0;
            e2_reg    <= '0;
            accum_reg <= '0;
        end else begin
            if (ctrl.ld1) begin
                e1_reg <= en ? e_c : '0;
                e2_reg <= en ? e1_reg : '0;
            end
            if (ctrl.ld2) begin
                accum_reg <= accum_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld1) begin
            pkp_reg <= pkp_next;
            pki_reg <= pki_next;
            pkd_reg <= pkd_next;
        end
        if (ctrl.ld3) begin
            adj_reg <= adj_next;
        end
    end

endmodule

// ===== rtl/dual_incremental_pid_q10_top.sv =====
// Two-wheel incremental (velocity-form) PID speed regulator with Q10 gains.
// One beat in carries target, measured speed and base drive for each wheel; one beat
// out carries the clamped drives and the adjustments. The block takes a beat every
// cycle unless back-pressure from m_tready stalls it. Each beat passes through five
// registers (input register, gain products, accumulator, adjustment, output register)
// before m_tvalid rises; each wheel's saturating accumulator is updated once per beat,
// so a new beat can follow the last one without waiting. Stages fill bubbles
// independently, so a beat is still taken while a result waits at the output.
// Registers are written through the cfg port at any time, one per cycle, but take
// effect cleanly only while no beat is in flight.
// Depends on dipq_pkg, dipq_cfg, dipq_wheel and the defines header.
`include "dual_incremental_pid_q10_top_defines.svh"

module dual_incremental_pid_q10_top #(
    parameter int ACCUM_WIDTH = 48,
    parameter int FRAC_BITS   = 10
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // left_target, left_measured, left_base, right_target, right_measured,
    // right_base, zero pad
    input  logic [dipq_pkg::S_TDATA_W-1:0]          s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // left_drive, right_drive, left_adjust, right_adjust, zero pad
    output logic [dipq_pkg::M_TDATA_W-1:0]          m_tdata,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [dipq_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [dipq_pkg::CFG_DATA_W-1:0]         cfg_data
);

    dipq_pkg::cfg_regs_t    regs;
    dipq_pkg::stage_ctrl_t  ctrl;

    logic v0_reg, v1_reg, v2_reg, v3_reg, m_tvalid_reg;
    logic ready1, ready2, ready3, ready4, ld4, s_acc;

    logic signed [dipq_pkg::SPEED_W-1:0] lt_reg, lm_reg, rt_reg, rm_reg;
    logic signed [dipq_pkg::BASE_W-1:0]  lb0_reg, lb1_reg, lb2_reg, lb3_reg;
    logic signed [dipq_pkg::BASE_W-1:0]  rb0_reg, rb1_reg, rb2_reg, rb3_reg;
    logic signed [dipq_pkg::ADJ_W-1:0]   l_adj, r_adj;

    logic signed [dipq_pkg::DRIVE_W-1:0] m_left_drive_reg, m_left_drive_next;
    logic signed [dipq_pkg::DRIVE_W-1:0] m_right_drive_reg, m_right_drive_next;
    logic signed [dipq_pkg::ADJ_W-1:0]   m_left_adjust_reg, m_right_adjust_reg;

    logic signed [dipq_pkg::DSUM_W-1:0]  lim_s, l_sum, r_sum;

    logic l_adj_ok, r_adj_ok;

    dipq_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (regs)
    );

    // stage handshake: each stage advances when the next one is empty or moving
    always_comb begin
        ready4   = !m_tvalid_reg || m_tready;
        ready3   = !v3_reg || ready4;
        ready2   = !v2_reg || ready3;
        ready1   = !v1_reg || ready2;
        s_tready = !v0_reg || ready1;
        s_acc    = s_tvalid && s_tready;
        ctrl.ld1 = v0_reg && ready1;
        ctrl.ld2 = v1_reg && ready2;
        ctrl.ld3 = v2_reg && ready3;
        ld4      = v3_reg && ready4;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg       <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            v0_reg       <= s_acc | (v0_reg & ~ctrl.ld1);
            v1_reg       <= ctrl.ld1 | (v1_reg & ~ctrl.ld2);
            v2_reg       <= ctrl.ld2 | (v2_reg & ~ctrl.ld3);
            v3_reg       <= ctrl.ld3 | (v3_reg & ~ld4);
            m_tvalid_reg <= ld4 | (m_tvalid_reg & ~m_tready);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            lt_reg  <= $signed(s_tdata[15:0]);
            lm_reg  <= $signed(s_tdata[31:16]);
            lb0_reg <= $signed(s_tdata[48:32]);
            rt_reg  <= $signed(s_tdata[64:49]);
            rm_reg  <= $signed(s_tdata[80:65]);
            rb0_reg <= $signed(s_tdata[97:81]);
        end
        if (ctrl.ld1) begin
            lb1_reg <= lb0_reg;
            rb1_reg <= rb0_reg;
        end
        if (ctrl.ld2) begin
            lb2_reg <= lb1_reg;
            rb2_reg <= rb1_reg;
        end
        if (ctrl.ld3) begin
            lb3_reg <= lb2_reg;
            rb3_reg <= rb2_reg;
        end
        if (ld4) begin
            m_left_drive_reg   <= m_left_drive_next;
            m_right_drive_reg  <= m_right_drive_next;
            m_left_adjust_reg  <= l_adj;
            m_right_adjust_reg <= r_adj;
        end
    end

    dipq_wheel #(
        .ACCUM_WIDTH (ACCUM_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .en      (regs.enable_mask[0]),
        .kp      (regs.left_kp),
        .ki      (regs.left_ki),
        .kd      (regs.left_kd),
        .lim     (regs.motor_limit),
        .target  (lt_reg),
        .meas    (lm_reg),
        .adjust  (l_adj)
    );

    dipq_wheel #(
        .ACCUM_WIDTH (ACCUM_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .en      (regs.enable_mask[1]),
        .kp      (regs.right_kp),
        .ki      (regs.right_ki),
        .kd      (regs.right_kd),
        .lim     (regs.motor_limit),
        .target  (rt_reg),
        .meas    (rm_reg),
        .adjust  (r_adj)
    );

    // base plus adjustment, clamped to the drive limit
    always_comb begin
        lim_s = $signed(dipq_pkg::DSUM_W'(regs.motor_limit));
        l_sum = dipq_pkg::DSUM_W'(lb3_reg) + dipq_pkg::DSUM_W'(l_adj);
        r_sum = dipq_pkg::DSUM_W'(rb3_reg) + dipq_pkg::DSUM_W'(r_adj);
        if (l_sum > lim_s) begin
            m_left_drive_next = dipq_pkg::DRIVE_W'(lim_s);
        end else if (l_sum < -lim_s) begin
            m_left_drive_next = dipq_pkg::DRIVE_W'(-lim_s);
        end else begin
            m_left_drive_next = dipq_pkg::DRIVE_W'(l_sum);
        end
        if (r_sum > lim_s) begin
            m_right_drive_next = dipq_pkg::DRIVE_W'(lim_s);
        end else if (r_sum < -lim_s) begin
            m_right_drive_next = dipq_pkg::DRIVE_W'(-lim_s);
        end else begin
            m_right_drive_next = dipq_pkg::DRIVE_W'(r_sum);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_right_adjust_reg, m_left_adjust_reg,
                       m_right_drive_reg, m_left_drive_reg};

    assign l_adj_ok = (m_left_adjust_reg <= dipq_pkg::ADJ_LIM)
                   && (m_left_adjust_reg >= -dipq_pkg::ADJ_LIM);
    assign r_adj_ok = (m_right_adjust_reg <= dipq_pkg::ADJ_LIM)
                   && (m_right_adjust_reg >= -dipq_pkg::ADJ_LIM);

    `DIPQ_ASSERT_IMPL(a_s1_no_overrun, ctrl.ld1 && v1_reg, ctrl.ld2, "stage 1 overwritten")
    `DIPQ_ASSERT_IMPL(a_out_no_overrun, ld4 && m_tvalid_reg, m_tready, "output overwritten")
    `DIPQ_ASSERT_NEXT(a_s2_hold, v2_reg && !ctrl.ld3, v2_reg, "stage 2 beat lost")
    `DIPQ_ASSERT_IMPL(a_adjust_range, m_tvalid_reg, l_adj_ok && r_adj_ok, "adjust out of range")

endmodule

// ===== tb/tb_dual_incremental_pid_q10_top.sv =====
// Self-checking bench for dual_incremental_pid_q10_top: streams wheel commands and checks drives.
// A scoreboard class predicts both velocity-form loops; depends on dipq_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_dual_incremental_pid_q10_top;

    localparam int RUN_LIMIT  = 1_500_000;
    localparam int SAT_BEATS  = 60;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_BEATS = 200;

    // fields from the lowest bit up: left_target, left_measured, left_base,
    // right_target, right_measured, right_base, zero pad
    typedef struct packed {
        logic [5:0]         pad;
        logic signed [16:0] right_base;
        logic signed [15:0] right_measured;
        logic signed [15:0] right_target;
        logic signed [16:0] left_base;
        logic signed [15:0] left_measured;
        logic signed [15:0] left_target;
    } wheel_cmd_t;

    // fields from the lowest bit up: left_drive, right_drive, left_adjust, right_adjust, pad
    typedef struct packed {
        logic [1:0]         pad;
        logic signed [17:0] right_adjust;
        logic signed [17:0] left_adjust;
        logic signed [16:0] right_drive;
        logic signed [16:0] left_drive;
    } drive_beat_t;

    class wheel_drive_checker;
        localparam longint ACC_MAX = (64'sd1 <<< 47) - 1;
        localparam longint ACC_MIN = -(64'sd1 <<< 47);

        logic [13:0] gain [6];
        logic [1:0]  mask;
        logic [15:0] limit;
        longint      accum [2];
        longint      err1 [2];
        longint      err2 [2];
        drive_beat_t drives_due [$];
        int          checked;
        int          errors;

        function new();
            foreach (gain[i]) gain[i] = '0;
            mask  = dipq_pkg::MASK_RESET;
            limit = dipq_pkg::LIMIT_RESET;
            for (int w = 0; w < 2; w++) begin
                accum[w] = 0;
                err1[w]  = 0;
                err2[w]  = 0;
            end
            checked = 0;
            errors  = 0;
        endfunction

        function void write_reg(logic [3:0] idx, logic [15:0] data);
            case (idx)
                dipq_pkg::REG_LEFT_KP:     gain[0] = data[13:0];
                dipq_pkg::REG_LEFT_KI:     gain[1] = data[13:0];
                dipq_pkg::REG_LEFT_KD:     gain[2] = data[13:0];
                dipq_pkg::REG_RIGHT_KP:    gain[3] = data[13:0];
                dipq_pkg::REG_RIGHT_KI:    gain[4] = data[13:0];
                dipq_pkg::REG_RIGHT_KD:    gain[5] = data[13:0];
                dipq_pkg::REG_ENABLE_MASK: mask    = data[1:0];
                dipq_pkg::REG_MOTOR_LIMIT: limit   = data;
                default: ;
            endcase
        endfunction

        function longint clamp_sym(longint v, longint lim);
            if (v > lim) return lim;
            if (v < -lim) return -lim;
            return v;
        endfunction

        function longint loop_adjust(int w, bit en, longint tgt, longint meas);
            longint e, inc, u, kp, ki, kd, lim;
            kp  = gain[3*w];
            ki  = gain[3*w+1];
            kd  = gain[3*w+2];
            lim = limit;
            if (!en) begin
                accum[w] = 0;
                err1[w]  = 0;
                err2[w]  = 0;
                return 0;
            end
            e   = meas - tgt;
            inc = kp * (e - err1[w]) + ki * e + kd * (e - 2 * err1[w] + err2[w]);
            accum[w] = accum[w] + inc;
            if (accum[w] > ACC_MAX) accum[w] = ACC_MAX;
            if (accum[w] < ACC_MIN) accum[w] = ACC_MIN;
            err2[w] = err1[w];
            err1[w] = e;
            u = clamp_sym(accum[w], (lim * 2) <<< 10);
            return -(u >>> 10);
        endfunction

        function void note_command(wheel_cmd_t c);
            drive_beat_t x;
            longint      la, ra;
            la = loop_adjust(0, mask[0], c.left_target, c.left_measured);
            ra = loop_adjust(1, mask[1], c.right_target, c.right_measured);
            x.pad          = '0;
            x.left_adjust  = 18'(la);
            x.right_adjust = 18'(ra);
            x.left_drive   = 17'(clamp_sym(c.left_base + la, limit));
            x.right_drive  = 17'(clamp_sym(c.right_base + ra, limit));
            drives_due.push_back(x);
        endfunction

        function void flag(string what, logic signed [17:0] want, logic signed [17:0] got);
            errors++;
            if (errors <= 10)
                $display("mismatch on %s at result %0d: expected %0d, got %0d",
                         what, checked, want, got);
        endfunction

        function void check_drive(drive_beat_t got);
            drive_beat_t want;
            if (drives_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat %h with nothing outstanding", got);
                return;
            end
            want = drives_due.pop_front();
            if (got.left_drive !== want.left_drive)
                flag("left_drive", want.left_drive, got.left_drive);
            if (got.right_drive !== want.right_drive)
                flag("right_drive", want.right_drive, got.right_drive);
            if (got.left_adjust !== want.left_adjust)
                flag("left_adjust", want.left_adjust, got.left_adjust);
            if (got.right_adjust !== want.right_adjust)
                flag("right_adjust", want.right_adjust, got.right_adjust);
            if (got.pad !== 2'b00)
                flag("pad", 0, got.pad);
            checked++;
        endfunction
    endclass

    logic                                aclk      = 1'b0;
    logic                                aresetn   = 1'b0;
    logic                                s_tvalid  = 1'b0;
    logic                                s_tready;
    logic [dipq_pkg::S_TDATA_W-1:0]      s_tdata   = '0;
    logic                                m_tvalid;
    logic                                m_tready  = 1'b0;
    logic [dipq_pkg::M_TDATA_W-1:0]      m_tdata;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [dipq_pkg::CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [dipq_pkg::CFG_DATA_W-1:0]     cfg_data  = '0;

    wheel_drive_checker sb = new();
    int  send_idle  = 0;
    int  recv_idle  = 0;
    bit  hold_off   = 1'b0;
    int  cycles     = 0;
    int  beats_sent = 0;

    dual_incremental_pid_q10_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // take result beats, stall at random or while held off
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_drive(m_tdata);
        m_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end

    task automatic send_beat(wheel_cmd_t c);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge aclk); while (!s_tready);
        sb.note_command(c);
        beats_sent++;
    endtask

    task automatic send_speeds(logic signed [15:0] lt, logic signed [15:0] lm,
                               logic signed [16:0] lb, logic signed [15:0] rt,
                               logic signed [15:0] rm, logic signed [16:0] rb);
        wheel_cmd_t c;
        c = '{pad: '0, right_base: rb, right_measured: rm, right_target: rt,
              left_base: lb, left_measured: lm, left_target: lt};
        send_beat(c);
    endtask

    // drain every outstanding result, then let the pipeline go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.drives_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic write_gains(logic [15:0] lkp, logic [15:0] lki, logic [15:0] lkd,
                               logic [15:0] rkp, logic [15:0] rki, logic [15:0] rkd,
                               logic [15:0] en, logic [15:0] lim);
        write_reg(dipq_pkg::REG_LEFT_KP, lkp);
        write_reg(dipq_pkg::REG_LEFT_KI, lki);
        write_reg(dipq_pkg::REG_LEFT_KD, lkd);
        write_reg(dipq_pkg::REG_RIGHT_KP, rkp);
        write_reg(dipq_pkg::REG_RIGHT_KI, rki);
        write_reg(dipq_pkg::REG_RIGHT_KD, rkd);
        write_reg(dipq_pkg::REG_ENABLE_MASK, en);
        write_reg(dipq_pkg::REG_MOTOR_LIMIT, lim);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'(10240);
            3:       return 16'($urandom);
            default: return 16'($urandom_range(2048));
        endcase
    endfunction

    function automatic logic signed [15:0] pick_speed_extreme();
        case ($urandom_range(3))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return 16'sd0;
            default: return -16'sd1;
        endcase
    endfunction

    function automatic wheel_cmd_t random_cmd();
        wheel_cmd_t c;
        int         t, d;
        c = '0;
        c.left_base  = 17'($urandom);
        c.right_base = 17'($urandom);
        case ($urandom_range(7))
            0, 1, 2: begin
                c.left_target    = 16'($urandom);
                c.left_measured  = 16'($urandom);
                c.right_target   = 16'($urandom);
                c.right_measured = 16'($urandom);
            end
            3: begin
                c.left_target    = pick_speed_extreme();
                c.left_measured  = pick_speed_extreme();
                c.right_target   = pick_speed_extreme();
                c.right_measured = pick_speed_extreme();
            end
            default: begin
                // track near the target so the loop stays inside its clamps
                t = $urandom_range(4000) - 2000;
                d = $urandom_range(200) - 100;
                c.left_target    = 16'(t);
                c.left_measured  = 16'(t + d);
                t = $urandom_range(4000) - 2000;
                d = $urandom_range(200) - 100;
                c.right_target   = 16'(t);
                c.right_measured = 16'(t + d);
                c.left_base      = 17'($urandom_range(8000) - 4000);
                c.right_base     = 17'($urandom_range(8000) - 4000);
            end
        endcase
        return c;
    endfunction

    task automatic load_phase_config(int p);
        logic [15:0] lim, en;
        case (p)
            0:       lim = 16'hFFFF;
            1:       lim = 16'd1;
            2:       lim = 16'd0;
            3:       lim = 16'($urandom_range(200, 20));
            default: lim = 16'($urandom_range(65535, 1));
        endcase
        en = (p == 0 || $urandom_range(1)) ? 16'd3 : 16'($urandom);
        // out-of-map index must leave the registers alone
        write_reg(4'(8 + $urandom_range(7)), 16'($urandom));
        if (p == 0)
            write_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, en, lim);
        else
            write_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                        pick_gain(), en, lim);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (4) @(posedge aclk);

        // reset settings: zero gains, both loops on, limit 3600
        send_speeds(16'sd32767, -16'sd32768, 17'sd65535, -16'sd32768, 16'sd32767, -17'sd65536);
        send_speeds(16'sd0, 16'sd0, -17'sd3601, 16'sd0, 16'sd0, 17'sd3601);
        settle();

        write_gains(16'd1024, 16'd256, 16'd512, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd3, 16'hFFFF);
        send_speeds(-16'sd32768, 16'sd32767, 17'sd0, 16'sd32767, -16'sd32768, 17'sd0);
        send_speeds(16'sd32767, -16'sd32768, 17'sd65535, -16'sd32768, 16'sd32767, -17'sd65535);
        send_speeds(16'sd100, 16'sd100, -17'sd65536, 16'sd0, 16'sd0, 17'sd65535);
        send_speeds(16'sd0, 16'sd5, 17'sd1000, 16'sd0, -16'sd5, -17'sd1000);
        send_speeds(16'sd0, -16'sd1, 17'sd0, 16'sd0, 16'sd1, 17'sd0);
        send_speeds(16'sd0, 16'sd0, 17'sd0, 16'sd0, 16'sd0, 17'sd0);
        settle();

        // disabled wheels clear their history
        write_reg(dipq_pkg::REG_ENABLE_MASK, 16'd1);
        cfg_valid <= 1'b0;
        send_speeds(16'sd10, 16'sd300, 17'sd50, 16'sd10, 16'sd300, 17'sd70000);
        send_speeds(16'sd10, 16'sd300, 17'sd50, 16'sd10, 16'sd300, -17'sd70000);
        settle();
        write_reg(dipq_pkg::REG_ENABLE_MASK, 16'd0);
        cfg_valid <= 1'b0;
        send_speeds(16'sd10, 16'sd300, 17'sd65535, 16'sd10, 16'sd300, -17'sd65536);
        settle();
        write_reg(dipq_pkg::REG_ENABLE_MASK, 16'd2);
        cfg_valid <= 1'b0;
        send_speeds(16'sd10, 16'sd300, 17'sd50, 16'sd10, 16'sd300, 17'sd50);
        settle();

        // limit collapsed to zero, then to one
        write_reg(dipq_pkg::REG_ENABLE_MASK, 16'd3);
        write_reg(dipq_pkg::REG_MOTOR_LIMIT, 16'd0);
        cfg_valid <= 1'b0;
        send_speeds(16'sd0, 16'sd2000, 17'sd65535, 16'sd0, -16'sd2000, -17'sd65536);
        send_speeds(16'sd0, -16'sd2000, 17'sd5, 16'sd0, 16'sd2000, -17'sd5);
        settle();
        write_reg(dipq_pkg::REG_MOTOR_LIMIT, 16'd1);
        write_reg(4'd8, 16'hFFFF);
        write_reg(4'd15, 16'h0000);
        cfg_valid <= 1'b0;
        send_speeds(16'sd0, 16'sd2000, 17'sd0, 16'sd0, -16'sd2000, 17'sd0);
        send_speeds(16'sd0, 16'sd1, 17'sd1, 16'sd0, -16'sd1, -17'sd1);
        settle();

        // push both accumulators hard one way, then back the other way
        write_reg(dipq_pkg::REG_ENABLE_MASK, 16'd0);
        cfg_valid <= 1'b0;
        send_speeds(16'sd0, 16'sd0, 17'sd0, 16'sd0, 16'sd0, 17'sd0);
        settle();
        write_gains(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd3, 16'hFFFF);
        for (int i = 0; i < SAT_BEATS; i++)
            send_speeds(-16'sd32768, 16'sd32767, 17'($urandom), 16'sd32767, -16'sd32768,
                        17'($urandom));
        for (int i = 0; i < SAT_BEATS; i++)
            send_speeds(16'sd32767, -16'sd32768, 17'($urandom), -16'sd32768, 16'sd32767,
                        17'($urandom));
        settle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            settle();
            if (p < 2) begin
                send_idle = 29;
                recv_idle = 66;
            end else if (p < 4) begin
                send_idle = 66;
                recv_idle = 29;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            load_phase_config(p);
            for (int i = 0; i < PHASE_BEATS; i++) begin
                if (p == 1 && i == 40) begin
                    fork
                        begin
                            hold_off <= 1'b1;
                            repeat (200) @(posedge aclk);
                            hold_off <= 1'b0;
                        end
                    join_none
                end
                if (p == 3 && i == 120) begin
                    s_tvalid <= 1'b0;
                    while (sb.drives_due.size() != 0) @(posedge aclk);
                end
                send_beat(random_cmd());
            end
        end
        settle();
        repeat (12) @(posedge aclk);

        $display("run covered %0d command beats: directed edges, large accumulator swings and",
                 beats_sent);
        $display("%0d randomised register settings; %0d result beats checked, %0d mismatches",
                 RAND_PHASES, sb.checked, sb.errors);
        if (sb.errors == 0 && sb.drives_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d expected results never arrived", sb.drives_due.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
